@@ design/assert_macros.svh @@
// Assertion helpers, included by the scheduler unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");

`endif

@@ design/rrts_pkg.sv @@
package rrts_pkg;

   localparam int TASK_SLOTS_DEF = 32;
   localparam int TASK_SLOTS_MAX = 64;
   // Wide enough to hold any slot number and the slot count itself.
   localparam int TGT_W = $clog2(TASK_SLOTS_MAX) + 1;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 80;

   typedef enum logic [2:0] {
      ACT_YIELD  = 3'd0,
      ACT_START  = 3'd1,
      ACT_STOP   = 3'd2,
      ACT_HALT   = 3'd3,
      ACT_RESUME = 3'd4,
      ACT_CHECK  = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      RC_OK       = 2'd0,
      RC_NO_FREE  = 2'd1,
      RC_ALL_STOP = 2'd2,
      RC_NO_RUN   = 2'd3
   } rc_type;

   typedef enum logic [1:0] {
      STS_INACTIVE = 2'd0,
      STS_RUNNABLE = 2'd1,
      STS_HALTED   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic start;
      logic free_mode;
   } scan_ctl_type;

   typedef struct packed {
      logic busy;
      logic hit;
      logic miss;
   } scan_stat_type;

endpackage

@@ design/round_robin_task_scheduler_unit.sv @@
// Round-robin task scheduler for TASK_SLOTS slots. Each request item is one command
// (yield, start, stop, halt, resume, check) and gives exactly one response item with
// the running task and both masks. A command is taken in ST_IDLE and its response is
// registered in ST_FINISH, which waits while the previous response is still stalled;
// explicit start, check, unused codes and commands that find every task stopped go
// straight there. A yield, or a stop, halt or resume (which end in a yield), and a
// start of the lowest free slot first pass through ST_SCAN, where a shared probe unit
// tests one slot per cycle. A new request is taken only once the previous response has
// been registered, and a response waits in the output register while the sink stalls.
module round_robin_task_scheduler_unit #(
   parameter int TASK_SLOTS = rrts_pkg::TASK_SLOTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // action [2:0], task_index [7:3], implicit_task [8], zero [15:9]
   input  logic [rrts_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // current_task [4:0], task_status [6:5], started_task [11:7], result_code [13:12],
   // active_mask [45:14], halted_mask [77:46], zero [79:78]
   output logic [rrts_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import rrts_pkg::*;

   localparam int SW = $clog2(TASK_SLOTS);
   localparam logic [TASK_SLOTS-1:0] SLOT_ONE = TASK_SLOTS'(1);

   state_type                 state_ff, state_in;
   logic [TASK_SLOTS-1:0]     active_ff, active_in;
   logic [TASK_SLOTS-1:0]     halted_ff, halted_in;
   logic [SW-1:0]             running_ff, running_in;
   status_type                status_ff, status_in;
   logic [SW-1:0]             started_ff, started_in;
   rc_type                    rc_ff, rc_in;
   logic                      free_scan_ff, free_scan_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;

   action_type                action;
   logic                      implicit_task;
   logic [TGT_W-1:0]          target_wide;
   logic                      target_ok;
   logic [TASK_SLOTS-1:0]     target_bit;
   logic [TASK_SLOTS-1:0]     start_active;
   logic                      yield_go;
   scan_ctl_type              scan_ctl;
   scan_stat_type             scan_stat;
   logic [SW-1:0]             scan_slot;

   rrts_scan #(
      .TASK_SLOTS(TASK_SLOTS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .scan_ctl    (scan_ctl),
      .base_slot   (running_ff),
      .active_bits (active_ff),
      .halted_bits (halted_ff),
      .scan_stat   (scan_stat),
      .scan_slot   (scan_slot)
   );

   assign action        = action_type'(req_tdata[2:0]);
   assign implicit_task = req_tdata[8];
   assign target_wide   = implicit_task ? TGT_W'(running_ff) : TGT_W'(req_tdata[7:3]);
   assign target_ok     = (target_wide < TGT_W'(TASK_SLOTS));
   assign target_bit    = target_ok ? (SLOT_ONE << target_wide) : '0;
   // A start on an empty set first brings slot 0 to life.
   assign start_active  = (active_ff == '0) ? SLOT_ONE : active_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in = state_ff;
      active_in = active_ff;
      halted_in = halted_ff;
      running_in = running_ff;
      status_in = status_ff;
      started_in = started_ff;
      rc_in = rc_ff;
      free_scan_in = free_scan_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in = rsp_data_ff;
      scan_ctl = '0;
      yield_go = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               status_in = STS_INACTIVE;
               started_in = '0;
               rc_in = RC_OK;
               state_in = ST_FINISH;
               case (action)
                  ACT_YIELD: begin
                     yield_go = 1'b1;
                  end
                  ACT_STOP: begin
                     active_in = active_ff & ~target_bit;
                     halted_in = halted_ff & ~target_bit;
                     yield_go = 1'b1;
                  end
                  ACT_HALT: begin
                     halted_in = halted_ff | target_bit;
                     yield_go = 1'b1;
                  end
                  ACT_RESUME: begin
                     halted_in = halted_ff & ~target_bit;
                     yield_go = 1'b1;
                  end
                  ACT_START: begin
                     active_in = start_active;
                     if (active_ff == '0) begin
                        running_in = '0;
                     end
                     if (implicit_task) begin
                        scan_ctl.start = 1'b1;
                        scan_ctl.free_mode = 1'b1;
                        free_scan_in = 1'b1;
                        state_in = ST_SCAN;
                     end else if (target_ok) begin
                        active_in = start_active | target_bit;
                        running_in = target_wide[SW-1:0];
                        started_in = target_wide[SW-1:0];
                     end else begin
                        rc_in = RC_NO_FREE;
                     end
                  end
                  ACT_CHECK: begin
                     if ((active_ff & target_bit) == '0) begin
                        status_in = STS_INACTIVE;
                     end else if ((halted_ff & target_bit) != '0) begin
                        status_in = STS_HALTED;
                     end else begin
                        status_in = STS_RUNNABLE;
                     end
                  end
                  default: begin
                  end
               endcase
               if (yield_go) begin
                  if (active_in == '0) begin
                     rc_in = RC_ALL_STOP;
                  end else begin
                     scan_ctl.start = 1'b1;
                     scan_ctl.free_mode = 1'b0;
                     free_scan_in = 1'b0;
                     state_in = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (scan_stat.hit) begin
               running_in = scan_slot;
               rc_in = RC_OK;
               if (free_scan_ff) begin
                  active_in = active_ff | (SLOT_ONE << scan_slot);
                  started_in = scan_slot;
               end
               state_in = ST_FINISH;
            end else if (scan_stat.miss) begin
               rc_in = free_scan_ff ? RC_NO_FREE : RC_NO_RUN;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {2'b00, 32'(halted_ff), 32'(active_ff), rc_ff,
                              5'(started_ff), status_ff, 5'(running_ff)};
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         active_ff <= '0;
         halted_ff <= '0;
         running_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         active_ff <= active_in;
         halted_ff <= halted_in;
         running_ff <= running_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff <= status_in;
      started_ff <= started_in;
      rc_ff <= rc_in;
      free_scan_ff <= free_scan_in;
      rsp_data_ff <= rsp_data_in;
   end

`include "assert_macros.svh"

   `ASSERT_SAME(a_scan_in_state, clock, reset, state_ff == ST_SCAN, scan_stat.busy)
   `ASSERT_SAME(a_busy_in_scan, clock, reset, scan_stat.busy, state_ff == ST_SCAN)
   `ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_tvalid && req_tready, state_ff != ST_IDLE)

endmodule

@@ design/rrts_scan.sv @@
module rrts_scan #(
   parameter int TASK_SLOTS = rrts_pkg::TASK_SLOTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rrts_pkg::scan_ctl_type        scan_ctl,
   input  logic [$clog2(TASK_SLOTS)-1:0] base_slot,
   input  logic [TASK_SLOTS-1:0]         active_bits,
   input  logic [TASK_SLOTS-1:0]         halted_bits,
   output rrts_pkg::scan_stat_type       scan_stat,
   output logic [$clog2(TASK_SLOTS)-1:0] scan_slot
);
   import rrts_pkg::*;

   localparam int SW = $clog2(TASK_SLOTS);
   localparam logic [SW-1:0] LAST_SLOT = SW'(TASK_SLOTS - 1);

   logic [SW-1:0] probe_ff, probe_in;
   logic [SW-1:0] count_ff, count_in;
   logic          busy_ff, busy_in;
   logic          free_mode_ff, free_mode_in;
   logic          test;
   logic          exhausted;

   // One slot is tested per cycle: a free slot, or a runnable one.
   always_comb begin
      test = free_mode_ff ? ~active_bits[probe_ff]
                          : (active_bits[probe_ff] & ~halted_bits[probe_ff]);
      exhausted = (count_ff == LAST_SLOT);
      probe_in = probe_ff;
      count_in = count_ff;
      busy_in = busy_ff;
      free_mode_in = free_mode_ff;
      if (scan_ctl.start) begin
         // A yield starts just after the running task, so that task is tried last.
         if (scan_ctl.free_mode) begin
            probe_in = '0;
         end else if (base_slot == LAST_SLOT) begin
            probe_in = '0;
         end else begin
            probe_in = base_slot + 1'b1;
         end
         count_in = '0;
         busy_in = 1'b1;
         free_mode_in = scan_ctl.free_mode;
      end else if (busy_ff) begin
         if (test || exhausted) begin
            busy_in = 1'b0;
         end else begin
            probe_in = (probe_ff == LAST_SLOT) ? '0 : probe_ff + 1'b1;
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      probe_ff <= probe_in;
      count_ff <= count_in;
      free_mode_ff <= free_mode_in;
   end

   assign scan_stat.busy = busy_ff;
   assign scan_stat.hit  = busy_ff & test;
   assign scan_stat.miss = busy_ff & ~test & exhausted;
   assign scan_slot      = probe_ff;

endmodule
